// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int ReqW  = 3;
  localparam int ItemW = 16;
  localparam int HeadW = 17;

  typedef enum logic [ReqW-1:0] {
    REQ_ENQ      = 3'd0,
    REQ_PEEK_ONE = 3'd1,
    REQ_PEEK_TWO = 3'd2,
    REQ_DEQ_ONE  = 3'd3,
    REQ_DEQ_TWO  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ENQ_ONE = 3'd1,
    OP_ENQ_TWO = 3'd2,
    OP_DEQ_ONE = 3'd3,
    OP_DEQ_TWO = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    HEAD_ZERO      = 2'd0,
    HEAD_MINUS_ONE = 2'd1,
    HEAD_ONE       = 2'd2,
    HEAD_TWO       = 2'd3
  } head_sel_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HOLD  = 2'b10
  } state_e;

  typedef struct packed {
    op_e       op;
    logic      load;
    logic      ok;
    head_sel_e head_sel;
  } cmd_t;

  typedef struct packed {
    logic one_empty;
    logic two_empty;
    logic store_full;
    logic one_le_two;
  } status_t;

endpackage

// ===== design/bdq_req_if.sv =====
`timescale 1ns / 1ps

interface bdq_req_if;
  logic                        valid;
  logic                        ready;
  logic [bdq_pkg::ReqW-1:0]    req_type;
  logic [bdq_pkg::ItemW-1:0]   item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink (input valid, input req_type, input item_value, output ready);
endinterface

// ===== design/bdq_rsp_if.sv =====
`timescale 1ns / 1ps

interface bdq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic signed [bdq_pkg::HeadW-1:0] head_value;

  modport source (output valid, output ok, output head_value, input ready);
  modport sink (input valid, input ok, input head_value, output ready);
endinterface

// ===== design/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic [bdq_pkg::ReqW-1:0] req_type_i,
  output logic                     req_ready_o,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  input  bdq_pkg::status_t         status_i,
  output bdq_pkg::cmd_t            cmd_o
);

  bdq_pkg::state_e state_q, state_d;
  logic            accept;

  // The result register can take a new word in the cycle its old one leaves.
  assign req_ready_o = (state_q == bdq_pkg::ST_EMPTY) || rsp_ready_i;
  assign rsp_valid_o = (state_q == bdq_pkg::ST_HOLD);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = bdq_pkg::OP_NONE;
    cmd_o.head_sel = bdq_pkg::HEAD_ZERO;
    cmd_o.load     = accept;
    if (accept) begin
      case (req_type_i)
        bdq_pkg::REQ_ENQ: begin
          if (!status_i.store_full) begin
            cmd_o.ok = 1'b1;
            cmd_o.op = status_i.one_le_two ? bdq_pkg::OP_ENQ_ONE : bdq_pkg::OP_ENQ_TWO;
          end
        end
        bdq_pkg::REQ_PEEK_ONE: begin
          cmd_o.ok       = !status_i.one_empty;
          cmd_o.head_sel = status_i.one_empty ? bdq_pkg::HEAD_MINUS_ONE : bdq_pkg::HEAD_ONE;
        end
        bdq_pkg::REQ_PEEK_TWO: begin
          cmd_o.ok       = !status_i.two_empty;
          cmd_o.head_sel = status_i.two_empty ? bdq_pkg::HEAD_MINUS_ONE : bdq_pkg::HEAD_TWO;
        end
        bdq_pkg::REQ_DEQ_ONE: begin
          if (!status_i.one_empty) begin
            cmd_o.ok = 1'b1;
            cmd_o.op = bdq_pkg::OP_DEQ_ONE;
          end
        end
        bdq_pkg::REQ_DEQ_TWO: begin
          if (!status_i.two_empty) begin
            cmd_o.ok = 1'b1;
            cmd_o.op = bdq_pkg::OP_DEQ_TWO;
          end
        end
        default: begin
          cmd_o.ok = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::ST_EMPTY: begin
        if (accept) state_d = bdq_pkg::ST_HOLD;
      end
      bdq_pkg::ST_HOLD: begin
        if (rsp_ready_i && !accept) state_d = bdq_pkg::ST_EMPTY;
      end
      default: begin
        state_d = bdq_pkg::ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/bdq_dp.sv =====
`timescale 1ns / 1ps

module bdq_dp #(
  parameter int Capacity   = 16,
  parameter int ValueWidth = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bdq_pkg::ItemW-1:0]        item_value_i,
  input  bdq_pkg::cmd_t                    cmd_i,
  output bdq_pkg::status_t                 status_o,
  output logic                             ok_o,
  output logic signed [bdq_pkg::HeadW-1:0] head_value_o
);

  localparam int CntW = $clog2(Capacity + 1);

  logic [ValueWidth-1:0] store_q [Capacity];
  logic [ValueWidth-1:0] store_d [Capacity];
  logic [ValueWidth-1:0] wr_value;
  logic [CntW-1:0]       cnt_one_q, cnt_one_d;
  logic [CntW-1:0]       cnt_two_q, cnt_two_d;
  logic [CntW:0]         cnt_sum;
  logic                  ok_q;
  logic signed [bdq_pkg::HeadW-1:0] head_q, head_d;

  assign wr_value = ValueWidth'(item_value_i);
  assign cnt_sum  = (CntW + 1)'(cnt_one_q) + (CntW + 1)'(cnt_two_q);

  assign status_o.one_empty  = (cnt_one_q == '0);
  assign status_o.two_empty  = (cnt_two_q == '0);
  assign status_o.store_full = (cnt_sum >= (CntW + 1)'(Capacity));
  assign status_o.one_le_two = (cnt_one_q <= cnt_two_q);

  // Each entry either takes the new word, its neighbor toward the far end
  // of its queue on a dequeue, or keeps its value.
  for (genvar g = 0; g < Capacity; g++) begin : g_entry
    logic [ValueWidth-1:0] from_above;
    logic [ValueWidth-1:0] from_below;
    if (g < Capacity - 1) begin : g_above
      assign from_above = store_q[g+1];
    end else begin : g_no_above
      assign from_above = store_q[g];
    end
    if (g > 0) begin : g_below
      assign from_below = store_q[g-1];
    end else begin : g_no_below
      assign from_below = store_q[g];
    end
    assign store_d[g] =
        (cmd_i.op == bdq_pkg::OP_ENQ_ONE && cnt_one_q == CntW'(g)) ? wr_value :
        (cmd_i.op == bdq_pkg::OP_ENQ_TWO && cnt_two_q == CntW'(Capacity - 1 - g)) ? wr_value :
        (cmd_i.op == bdq_pkg::OP_DEQ_ONE && CntW'(g + 1) < cnt_one_q) ? from_above :
        (cmd_i.op == bdq_pkg::OP_DEQ_TWO && CntW'(Capacity - g) < cnt_two_q) ? from_below :
        store_q[g];
  end

  always_comb begin
    cnt_one_d = cnt_one_q;
    cnt_two_d = cnt_two_q;
    case (cmd_i.op)
      bdq_pkg::OP_ENQ_ONE: cnt_one_d = cnt_one_q + CntW'(1);
      bdq_pkg::OP_ENQ_TWO: cnt_two_d = cnt_two_q + CntW'(1);
      bdq_pkg::OP_DEQ_ONE: cnt_one_d = cnt_one_q - CntW'(1);
      bdq_pkg::OP_DEQ_TWO: cnt_two_d = cnt_two_q - CntW'(1);
      default: begin
        cnt_one_d = cnt_one_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.head_sel)
      bdq_pkg::HEAD_MINUS_ONE: head_d = '1;
      bdq_pkg::HEAD_ONE:       head_d = bdq_pkg::HeadW'(store_q[0]);
      bdq_pkg::HEAD_TWO:       head_d = bdq_pkg::HeadW'(store_q[Capacity-1]);
      default:                 head_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (cmd_i.load) begin
      ok_q   <= cmd_i.ok;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_one_q <= '0;
      cnt_two_q <= '0;
    end else begin
      cnt_one_q <= cnt_one_d;
      cnt_two_q <= cnt_two_d;
    end
  end

  assign ok_o         = ok_q;
  assign head_value_o = head_q;

endmodule

// ===== design/balanced_dual_queue_shared_buffer_unit.sv =====
`timescale 1ns / 1ps

// Two FIFO queues share one register store of CAPACITY entries: queue one
// fills from entry 0 upward, queue two from the top entry downward, and an
// enqueue joins the shorter queue (queue one on a tie). Each request gives
// exactly one response word carrying ok and head_value (the head on a good
// peek, -1 on a peek of an empty queue, 0 otherwise). The store shifts a
// whole queue in the cycle of a dequeue and the response is registered,
// so with the response side ready the block takes one request per clock;
// a new request is accepted in the same cycle the pending response is
// taken. No clearing pass runs after reset.
module balanced_dual_queue_shared_buffer_unit #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdq_req_if.sink       req_i,
  bdq_rsp_if.source     rsp_o
);

  bdq_pkg::cmd_t    cmd;
  bdq_pkg::status_t status;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bdq_dp #(
    .Capacity   (CAPACITY),
    .ValueWidth (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_value_i (req_i.item_value),
    .cmd_i        (cmd),
    .status_o     (status),
    .ok_o         (rsp_o.ok),
    .head_value_o (rsp_o.head_value)
  );

`ifndef SYNTHESIS
  a_op_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op != bdq_pkg::OP_NONE) |-> (req_i.valid && req_i.ready))
    else $error("store changed without an accepted request");

  a_no_enq_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.store_full |-> (cmd.op != bdq_pkg::OP_ENQ_ONE && cmd.op != bdq_pkg::OP_ENQ_TWO))
    else $error("enqueue into a full store");

  a_no_deq_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.one_empty |-> cmd.op != bdq_pkg::OP_DEQ_ONE) and
    (status.two_empty |-> cmd.op != bdq_pkg::OP_DEQ_TWO))
    else $error("dequeue from an empty queue");

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> rsp_o.valid)
    else $error("accepted request left no response word");
`endif

endmodule
